FILE: hw/rtl/bdq_pkg.sv
// shared types and constants of the bounded deque with delete
// no dependencies
package bdq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int LIMIT_W   = 5;

    localparam int M_TDATA_W = ((VALUE_W + FILL_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - FILL_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [VALUE_W-1:0]   value_t;
    typedef logic [FILL_W-1:0]    fill_t;
    typedef logic [LIMIT_W-1:0]   limit_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam limit_t LIMIT_RESET = limit_t'(16);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND,
        OP_TAKE_OLD,
        OP_TAKE_NEW,
        OP_DELETE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE,
        STATUS_FULL,
        STATUS_EMPTY,
        STATUS_NOT_FOUND
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_CHECK,
        SEQ_SHIFT_RD,
        SEQ_SHIFT_WR,
        SEQ_DONE
    } seq_state_t;

endpackage

FILE: hw/rtl/bounded_deque_with_delete.sv
// Bounded deque of words with delete by value. A small sequencer walks a cell
// memory with one write and one read port one entry at a time, reading, comparing
// and shifting through one shared comparator. Uses bdq_pkg. Sequence: an append, a
// refused append and any operation on an empty store go straight to the done state;
// a take from the newest end reads the newest entry; a take from the oldest end reads
// the oldest entry and then shifts each later entry down, and a delete reads and
// compares entries from the oldest end and on a match shifts each later entry down,
// since every search and shift step goes through the one memory read port.
// s_tready is high only while the sequencer is idle, so no new item is taken before
// the last one is through; a finished result waits in the output register while the
// next item is taken, and while that register is still held the next result waits
// in the done state. The fill limit (reset 16, values above the depth act as the
// depth, zero refuses all appends) may be written at any idle time through cfg.
module bounded_deque_with_delete
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bdq_pkg::VALUE_W-1:0]    s_tdata,   // value
    input  logic [bdq_pkg::OP_W-1:0]       s_tuser,   // op

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_tdata,   // taken_value, fill_count, zero pad
    output logic [bdq_pkg::STATUS_W-1:0]   m_tuser,   // status

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdq_pkg::LIMIT_W-1:0]    cfg_data   // fill_limit
);

    bdq_pkg::seq_state_t state_reg, state_next;
    bdq_pkg::op_t        op_reg, op_next;
    bdq_pkg::word_t      value_reg, value_next;
    bdq_pkg::idx_t       idx_reg, idx_next;
    bdq_pkg::cnt_t       occ_reg, occ_next;
    bdq_pkg::word_t      taken_reg, taken_next;
    bdq_pkg::status_t    status_reg, status_next;
    bdq_pkg::limit_t     limit_reg;

    logic                m_tvalid_reg;
    bdq_pkg::value_t     out_taken_reg;
    bdq_pkg::status_t    out_status_reg;
    bdq_pkg::fill_t      out_fill_reg;

    bdq_pkg::word_t      entry_mem [bdq_pkg::DEPTH];
    bdq_pkg::word_t      rd_data_reg;

    logic                rd_en;
    bdq_pkg::idx_t       rd_addr;
    logic                wr_en;
    bdq_pkg::idx_t       wr_addr;
    bdq_pkg::word_t      wr_data;
    logic                out_load;
    logic                out_free;

    bdq_pkg::op_t        in_op;
    bdq_pkg::word_t      in_word;
    bdq_pkg::cnt_t       occ_dec;
    bdq_pkg::cnt_t       idx_inc_cnt;
    logic                is_full;
    logic                is_empty;
    logic                match;
    logic                more;

    assign in_op       = bdq_pkg::op_t'(s_tuser);
    assign in_word     = bdq_pkg::word_t'(s_tdata);
    assign occ_dec     = occ_reg - bdq_pkg::cnt_t'(1);
    assign idx_inc_cnt = bdq_pkg::cnt_t'(idx_reg) + bdq_pkg::cnt_t'(1);
    assign is_full     = (32'(occ_reg) >= 32'(limit_reg)) || (32'(occ_reg) >= bdq_pkg::DEPTH);
    assign is_empty    = (occ_reg == '0);
    assign match       = (rd_data_reg == value_reg);
    assign more        = (idx_inc_cnt < occ_reg);
    assign out_free    = !m_tvalid_reg || m_tready;

    // cell memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::SEQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_op == bdq_pkg::OP_APPEND || is_empty)
                    begin
                        state_next = bdq_pkg::SEQ_DONE;
                    end
                    else
                    begin
                        state_next = bdq_pkg::SEQ_READ;
                    end
                end
            end
            bdq_pkg::SEQ_READ:
            begin
                state_next = bdq_pkg::SEQ_CHECK;
            end
            bdq_pkg::SEQ_CHECK:
            begin
                unique case (op_reg)
                    bdq_pkg::OP_TAKE_OLD:
                    begin
                        state_next = bdq_pkg::SEQ_SHIFT_RD;
                    end
                    bdq_pkg::OP_DELETE:
                    begin
                        if (match)
                        begin
                            state_next = bdq_pkg::SEQ_SHIFT_RD;
                        end
                        else if (more)
                        begin
                            state_next = bdq_pkg::SEQ_READ;
                        end
                        else
                        begin
                            state_next = bdq_pkg::SEQ_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = bdq_pkg::SEQ_DONE;
                    end
                endcase
            end
            bdq_pkg::SEQ_SHIFT_RD:
            begin
                state_next = more ? bdq_pkg::SEQ_SHIFT_WR : bdq_pkg::SEQ_DONE;
            end
            bdq_pkg::SEQ_SHIFT_WR:
            begin
                state_next = bdq_pkg::SEQ_SHIFT_RD;
            end
            bdq_pkg::SEQ_DONE:
            begin
                if (out_free)
                begin
                    state_next = bdq_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::SEQ_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        s_tready    = 1'b0;
        op_next     = op_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        taken_next  = taken_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            bdq_pkg::SEQ_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    value_next  = in_word;
                    taken_next  = '0;
                    status_next = bdq_pkg::STATUS_DONE;
                    idx_next    = (in_op == bdq_pkg::OP_TAKE_NEW) ? occ_dec[bdq_pkg::IDX_W-1:0] : '0;
                    unique case (in_op)
                        bdq_pkg::OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = bdq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = occ_reg[bdq_pkg::IDX_W-1:0];
                                wr_data  = in_word;
                                occ_next = occ_reg + bdq_pkg::cnt_t'(1);
                            end
                        end
                        bdq_pkg::OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = bdq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (is_empty)
                            begin
                                status_next = bdq_pkg::STATUS_EMPTY;
                            end
                        end
                    endcase
                end
            end
            bdq_pkg::SEQ_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            bdq_pkg::SEQ_CHECK:
            begin
                unique case (op_reg)
                    bdq_pkg::OP_TAKE_NEW:
                    begin
                        taken_next = rd_data_reg;
                        occ_next   = occ_dec;
                    end
                    bdq_pkg::OP_TAKE_OLD:
                    begin
                        taken_next = rd_data_reg;
                    end
                    bdq_pkg::OP_DELETE:
                    begin
                        if (!match)
                        begin
                            if (more)
                            begin
                                idx_next = idx_inc_cnt[bdq_pkg::IDX_W-1:0];
                            end
                            else
                            begin
                                status_next = bdq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = status_reg;
                    end
                endcase
            end
            bdq_pkg::SEQ_SHIFT_RD:
            begin
                if (more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc_cnt[bdq_pkg::IDX_W-1:0];
                end
                else
                begin
                    occ_next = occ_dec;
                end
            end
            bdq_pkg::SEQ_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_inc_cnt[bdq_pkg::IDX_W-1:0];
            end
            bdq_pkg::SEQ_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bdq_pkg::SEQ_IDLE;
            occ_reg      <= '0;
            limit_reg    <= bdq_pkg::LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        taken_reg  <= taken_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_taken_reg  <= bdq_pkg::value_t'(taken_reg);
            out_status_reg <= status_reg;
            out_fill_reg   <= bdq_pkg::fill_t'(occ_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{bdq_pkg::M_PAD_W{1'b0}}, out_fill_reg, out_taken_reg};
    assign m_tuser   = out_status_reg;

`ifndef SYNTHESIS
    // fill count stays within the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= bdq_pkg::DEPTH)
        else $error("fill count above depth");

    // a refused take can only happen on an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == bdq_pkg::STATUS_EMPTY) |-> (out_fill_reg == '0))
        else $error("empty status with nonzero fill count");

    // only a completed take returns a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != bdq_pkg::STATUS_DONE) |-> (out_taken_reg == '0))
        else $error("taken word on a refused operation");

    // cell writes stay inside the stored range or at the append slot
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (bdq_pkg::cnt_t'(wr_addr) <= occ_reg))
        else $error("cell write beyond fill count");
`endif

endmodule
